/* design/atrp_pkg.sv */
// ----------------------------------------------------------------------------
// atrp_pkg: shared types and constants for the accelerometer tilt core
// Fixed-point formats, the CORDIC arctangent table (degrees * 2^24) and the
// pitch pre-scale constant applied to the pass-two input.
// ----------------------------------------------------------------------------
package atrp_pkg;

  // sample and result widths
  localparam int IN_W      = 16;
  localparam int ROLL_W    = 16;
  localparam int PITCH_W   = 15;

  // vector components: sample * 2^GUARD_BITS, with headroom for CORDIC gain
  localparam int GUARD_BITS = 16;
  localparam int VEC_W      = 38;

  // angle accumulator: degrees * 2^ACC_FRAC
  localparam int ACC_FRAC = 24;
  localparam int ACC_W    = 34;
  localparam int TAB_LEN  = 24;

  localparam logic signed [ACC_W-1:0] DEG90 = ACC_W'(1509949440);

  // CORDIC gain K in Q30; product is floored back to the vector format
  localparam logic signed [31:0] KQ30     = 32'sd1768195363;
  localparam int                 KQ_SHIFT = 30 - GUARD_BITS;

  // round(atan(2^-i) in degrees * 2^24)
  function automatic logic signed [ACC_W-1:0] atan_entry(input int unsigned idx);
    case (idx)
      0:       return ACC_W'(754974720);
      1:       return ACC_W'(445687602);
      2:       return ACC_W'(235489088);
      3:       return ACC_W'(119537938);
      4:       return ACC_W'(60000934);
      5:       return ACC_W'(30029717);
      6:       return ACC_W'(15018523);
      7:       return ACC_W'(7509720);
      8:       return ACC_W'(3754917);
      9:       return ACC_W'(1877466);
      10:      return ACC_W'(938734);
      11:      return ACC_W'(469367);
      12:      return ACC_W'(234684);
      13:      return ACC_W'(117342);
      14:      return ACC_W'(58671);
      15:      return ACC_W'(29335);
      16:      return ACC_W'(14668);
      17:      return ACC_W'(7334);
      18:      return ACC_W'(3667);
      19:      return ACC_W'(1833);
      20:      return ACC_W'(917);
      21:      return ACC_W'(458);
      22:      return ACC_W'(229);
      23:      return ACC_W'(115);
      default: return '0;
    endcase
  endfunction

endpackage

/* design/atrp_vector.sv */
// ----------------------------------------------------------------------------
// atrp_vector: pipelined CORDIC vectoring pass
// One quadrant pre-rotation stage, then one register stage per
// micro-rotation. Returns angle (degrees * 2^24), scaled magnitude, and a
// sideband word that travels alongside the request.
// ----------------------------------------------------------------------------
module atrp_vector
  import atrp_pkg::*;
#(
  parameter int STEPS  = 16,
  parameter int SIDE_W = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [VEC_W-1:0] in_x,
  input  logic signed [VEC_W-1:0] in_y,
  input  logic [SIDE_W-1:0]       in_side,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VEC_W-1:0] out_mag,
  output logic signed [ACC_W-1:0] out_angle,
  output logic [SIDE_W-1:0]       out_side
);

  // per-stage registers; index 0 is the pre-rotation stage
  logic                    vld   [STEPS+1];
  logic                    rdy   [STEPS+1];
  logic signed [VEC_W-1:0] vx    [STEPS+1];
  logic signed [VEC_W-1:0] vy    [STEPS+1];
  logic signed [ACC_W-1:0] vacc  [STEPS+1];
  logic                    vzero [STEPS+1];
  logic [SIDE_W-1:0]       vside [STEPS+1];

  logic signed [VEC_W-1:0] pre_x;
  logic signed [VEC_W-1:0] pre_y;
  logic signed [ACC_W-1:0] pre_acc;

  // a stage takes new data when empty or when its successor moves
  for (genvar k = 0; k < STEPS; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end
  assign rdy[STEPS] = !vld[STEPS] || out_ready;
  assign in_ready   = rdy[0];

  // left half plane: rotate by 90 degrees toward the right half
  always_comb begin
    pre_x   = in_x;
    pre_y   = in_y;
    pre_acc = '0;
    if (in_x[VEC_W-1]) begin
      if (!in_y[VEC_W-1]) begin
        pre_x   = in_y;
        pre_y   = -in_x;
        pre_acc = DEG90;
      end else begin
        pre_x   = -in_y;
        pre_y   = in_x;
        pre_acc = -DEG90;
      end
    end
  end

  // pre-rotation stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      vx[0]    <= pre_x;
      vy[0]    <= pre_y;
      vacc[0]  <= pre_acc;
      vzero[0] <= (in_x == '0) && (in_y == '0);
      vside[0] <= in_side;
    end
  end

  // micro-rotation stages
  for (genvar k = 1; k <= STEPS; k++) begin : g_rot
    localparam logic signed [ACC_W-1:0] ANG = atan_entry(k - 1);

    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    logic signed [VEC_W-1:0] x_next;
    logic signed [VEC_W-1:0] y_next;
    logic signed [ACC_W-1:0] acc_next;

    // shifts floor toward minus infinity (arithmetic)
    always_comb begin
      dx = vy[k-1] >>> (k - 1);
      dy = vx[k-1] >>> (k - 1);
      if (!vy[k-1][VEC_W-1]) begin
        x_next   = vx[k-1] + dx;
        y_next   = vy[k-1] - dy;
        acc_next = vacc[k-1] + ANG;
      end else begin
        x_next   = vx[k-1] - dx;
        y_next   = vy[k-1] + dy;
        acc_next = vacc[k-1] - ANG;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        vx[k]    <= x_next;
        vy[k]    <= y_next;
        vacc[k]  <= acc_next;
        vzero[k] <= vzero[k-1];
        vside[k] <= vside[k-1];
      end
    end
  end

  // zero vector reports angle 0
  assign out_valid = vld[STEPS];
  assign out_mag   = vx[STEPS];
  assign out_angle = vzero[STEPS] ? '0 : vacc[STEPS];
  assign out_side  = vside[STEPS];

`ifndef SYNTH
  // a zero vector never picks up a component in the rotations
  a_zero_stays: assert property (@(posedge clk) disable iff (rst)
    out_valid && vzero[STEPS] |-> (vx[STEPS] == '0) && (vy[STEPS] == '0))
    else $error("atrp_vector: zero vector gained a component");

  // x never decreases after pre-rotation, so the magnitude is not negative
  a_mag_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !out_mag[VEC_W-1])
    else $error("atrp_vector: negative magnitude");

  // a stalled last stage keeps its request
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_side) && $stable(out_mag))
    else $error("atrp_vector: stalled request lost");
`endif

endmodule

/* design/accel_tilt_roll_pitch_core.sv */
// ----------------------------------------------------------------------------
// accel_tilt_roll_pitch_core: roll and pitch from one accelerometer sample
// Path from sample accept to angle_valid: input register, two vectoring passes
//   of CORDIC_STEPS + 1 stages each, output register.
// One sample per cycle unless angle_ready stalls; a stage per micro-rotation.
// Reset clears the valid bit of every stage; data registers are not reset.
// ----------------------------------------------------------------------------
module accel_tilt_roll_pitch_core
  import atrp_pkg::*;
#(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sample_valid,
  output logic                      sample_ready,
  input  logic signed [IN_W-1:0]    accel_x,
  input  logic signed [IN_W-1:0]    accel_y,
  input  logic signed [IN_W-1:0]    accel_z,
  output logic                      angle_valid,
  input  logic                      angle_ready,
  output logic signed [ROLL_W-1:0]  roll_angle,
  output logic signed [PITCH_W-1:0] pitch_angle
);

  localparam int SHR = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [ACC_W:0] RND = (ACC_W+1)'(1) <<< (SHR - 1);
  localparam logic signed [ACC_W:0] ROLL_LIM  = (ACC_W+1)'(180 * (2 ** ANGLE_FRAC_BITS));
  localparam logic signed [ACC_W:0] PITCH_LIM = (ACC_W+1)'(90 * (2 ** ANGLE_FRAC_BITS));
  localparam int EXT_W = VEC_W - IN_W - GUARD_BITS;

  // round half up to the output grid, then clamp
  function automatic logic signed [ACC_W:0] to_angle(input logic signed [ACC_W-1:0] acc,
                                                     input logic signed [ACC_W:0] lim);
    logic signed [ACC_W:0] r;
    r = ($signed({acc[ACC_W-1], acc}) + RND) >>> SHR;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  // input register
  logic                    vin;
  logic signed [IN_W-1:0]  sx;
  logic signed [IN_W-1:0]  sy;
  logic signed [IN_W-1:0]  sz;

  logic                    p1_in_ready;
  logic signed [VEC_W-1:0] p1_x;
  logic signed [VEC_W-1:0] p1_y;
  logic signed [IN_W:0]    negx;
  logic signed [48:0]      nx_prod;
  logic [VEC_W-1:0]        p1_side;
  logic                    p1_valid;
  logic signed [VEC_W-1:0] p1_mag;
  logic signed [ACC_W-1:0] p1_angle;
  logic [VEC_W-1:0]        p1_out_side;

  logic                    p2_in_ready;
  logic signed [ACC_W:0]   roll_wide;
  logic                    p2_valid;
  logic                    p2_out_ready;
  logic signed [VEC_W-1:0] p2_mag;
  logic signed [ACC_W-1:0] p2_angle;
  logic [ROLL_W-1:0]       p2_roll;
  logic signed [ACC_W:0]   pitch_wide;

  assign sample_ready = !vin || p1_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vin <= 1'b0;
    end else if (sample_ready) begin
      vin <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready) begin
      sx <= accel_x;
      sy <= accel_y;
      sz <= accel_z;
    end
  end

  // pass one works on (z, y); -x * K rides along for pass two
  assign p1_x    = {{EXT_W{sz[IN_W-1]}}, sz, {GUARD_BITS{1'b0}}};
  assign p1_y    = {{EXT_W{sy[IN_W-1]}}, sy, {GUARD_BITS{1'b0}}};
  assign negx    = -($signed({sx[IN_W-1], sx}));
  assign nx_prod = negx * KQ30;
  assign p1_side = VEC_W'(nx_prod >>> KQ_SHIFT);

  atrp_vector #(
    .STEPS  (CORDIC_STEPS),
    .SIDE_W (VEC_W)
  ) u_roll_pass (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vin),
    .in_ready  (p1_in_ready),
    .in_x      (p1_x),
    .in_y      (p1_y),
    .in_side   (p1_side),
    .out_valid (p1_valid),
    .out_ready (p2_in_ready),
    .out_mag   (p1_mag),
    .out_angle (p1_angle),
    .out_side  (p1_out_side)
  );

  // pass two works on (Kn*r, -x*K); formatted roll rides along
  assign roll_wide = to_angle(p1_angle, ROLL_LIM);

  atrp_vector #(
    .STEPS  (CORDIC_STEPS),
    .SIDE_W (ROLL_W)
  ) u_pitch_pass (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p1_valid),
    .in_ready  (p2_in_ready),
    .in_x      (p1_mag),
    .in_y      ($signed(p1_out_side)),
    .in_side   (roll_wide[ROLL_W-1:0]),
    .out_valid (p2_valid),
    .out_ready (p2_out_ready),
    .out_mag   (p2_mag),
    .out_angle (p2_angle),
    .out_side  (p2_roll)
  );

  // output register
  assign pitch_wide   = to_angle(p2_angle, PITCH_LIM);
  assign p2_out_ready = !angle_valid || angle_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_valid <= 1'b0;
    end else if (p2_out_ready) begin
      angle_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_out_ready) begin
      roll_angle  <= $signed(p2_roll);
      pitch_angle <= pitch_wide[PITCH_W-1:0];
    end
  end

`ifndef SYNTH
  // a stalled input register keeps its sample
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    vin && !p1_in_ready |=> vin && $stable(sx) && $stable(sy) && $stable(sz))
    else $error("accel_tilt_roll_pitch_core: input request lost");

  // zero magnitude from pass one only comes from y = z = 0, which gives roll 0
  a_roll_zero: assert property (@(posedge clk) disable iff (rst)
    p1_valid && (p1_mag == '0) |-> (p1_angle == '0))
    else $error("accel_tilt_roll_pitch_core: zero vector with nonzero roll");

  // pass two output waits while the output register is stalled
  a_p2_hold: assert property (@(posedge clk) disable iff (rst)
    p2_valid && angle_valid && !angle_ready |=> p2_valid && $stable(p2_angle))
    else $error("accel_tilt_roll_pitch_core: pitch request lost under stall");

  // pass-two magnitude is kept for checking only
  a_p2_mag: assert property (@(posedge clk) disable iff (rst)
    p2_valid |-> !p2_mag[VEC_W-1])
    else $error("accel_tilt_roll_pitch_core: negative pass-two magnitude");
`endif

endmodule
